[src/pva_pkg.sv]
// Shared types and constants for the packed vector ALU.
// Used by pva_lane, pva_merge and packed_vector_alu_256; depends on nothing else.
`default_nettype none

package pva_pkg;

	// Datapath geometry: four 64-bit lanes, each split into bytes.
	localparam int WORD_W    = 64;
	localparam int NUM_LANES = 4;
	localparam int BYTE_W    = 8;
	localparam int NUM_BYTES = WORD_W / BYTE_W;

	// Field widths of an input word.
	localparam int OP_W   = 2;
	localparam int SIZE_W = 2;

	// Stream word widths, padded to whole bytes.
	localparam int IN_RAW_W  = OP_W + SIZE_W + 9 * WORD_W;
	localparam int IN_W      = ((IN_RAW_W + 7) / 8) * 8;
	localparam int OUT_RAW_W = NUM_LANES * WORD_W + 1;
	localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;

	// Bit offsets inside the input stream word.
	localparam int IN_OP_LSB   = 0;
	localparam int IN_SIZE_LSB = IN_OP_LSB + OP_W;
	localparam int IN_A_LSB    = IN_SIZE_LSB + SIZE_W;
	localparam int IN_B_LSB    = IN_A_LSB + NUM_LANES * WORD_W;
	localparam int IN_S_LSB    = IN_B_LSB + NUM_LANES * WORD_W;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_BCAST = 2'd0;
	localparam logic [OP_W-1:0] OP_SUB   = 2'd1;
	localparam logic [OP_W-1:0] OP_CMPEQ = 2'd2;

	// Element size codes.
	localparam logic [SIZE_W-1:0] SZ_8  = 2'd0;
	localparam logic [SIZE_W-1:0] SZ_16 = 2'd1;
	localparam logic [SIZE_W-1:0] SZ_32 = 2'd2;
	localparam logic [SIZE_W-1:0] SZ_64 = 2'd3;

	// Status handed from the lane stage to the merging stage.
	typedef struct packed {
		logic                 cmp_op;
		logic [NUM_LANES-1:0] word_eq;
	} merge_in_t;

endpackage

`default_nettype wire

[src/pva_lane.sv]
// One 64-bit lane of the packed vector ALU: broadcast, subtract, compare equal.
// Depends on pva_pkg for codes and widths.
`default_nettype none

module pva_lane (
	input  wire logic [pva_pkg::OP_W-1:0]   opcode,
	input  wire logic [pva_pkg::SIZE_W-1:0] size_class,
	input  wire logic [pva_pkg::WORD_W-1:0] a,
	input  wire logic [pva_pkg::WORD_W-1:0] b,
	input  wire logic [pva_pkg::WORD_W-1:0] scalar_value,
	output logic      [pva_pkg::WORD_W-1:0] result,
	output logic                            word_eq
);
	import pva_pkg::*;

	logic [NUM_BYTES-1:0]   eq8;
	logic [NUM_BYTES/2-1:0] eq16;
	logic [NUM_BYTES/4-1:0] eq32;
	logic                   eq64;
	logic [NUM_BYTES-1:0]   lane_start;
	logic [WORD_W-1:0]      diff;
	logic [WORD_W-1:0]      eq_mask;
	logic [WORD_W-1:0]      splat;

	// Byte-wise equality, combined into wider elements.
	always_comb begin
		for (int k = 0; k < NUM_BYTES; k++) begin
			eq8[k] = (a[k*BYTE_W +: BYTE_W] == b[k*BYTE_W +: BYTE_W]);
		end
		for (int j = 0; j < NUM_BYTES / 2; j++) begin
			eq16[j] = eq8[2*j] & eq8[2*j+1];
		end
		for (int j = 0; j < NUM_BYTES / 4; j++) begin
			eq32[j] = eq16[2*j] & eq16[2*j+1];
		end
		eq64 = &eq32;
	end

	// Every element matches exactly when every byte matches.
	assign word_eq = eq64;

	// Mark the bytes that open a new element; the borrow chain restarts there.
	always_comb begin
		for (int k = 0; k < NUM_BYTES; k++) begin
			unique case (size_class)
				SZ_8:    lane_start[k] = 1'b1;
				SZ_16:   lane_start[k] = ((k % 2) == 0);
				SZ_32:   lane_start[k] = ((k % 4) == 0);
				default: lane_start[k] = (k == 0);
			endcase
		end
	end

	// Subtract as a + ~b + 1 per byte, carry passed on inside an element only.
	always_comb begin
		logic             carry;
		logic [BYTE_W:0]  sum;
		carry = 1'b1;
		for (int k = 0; k < NUM_BYTES; k++) begin
			sum = {1'b0, a[k*BYTE_W +: BYTE_W]} + {1'b0, ~b[k*BYTE_W +: BYTE_W]}
				+ {{BYTE_W{1'b0}}, (lane_start[k] | carry)};
			diff[k*BYTE_W +: BYTE_W] = sum[BYTE_W-1:0];
			carry = sum[BYTE_W] & ~(lane_start[k] & 1'b0);
		end
	end

	// Expand element matches into an all-ones or all-zeros mask per byte.
	always_comb begin
		for (int k = 0; k < NUM_BYTES; k++) begin
			unique case (size_class)
				SZ_8:    eq_mask[k*BYTE_W +: BYTE_W] = {BYTE_W{eq8[k]}};
				SZ_16:   eq_mask[k*BYTE_W +: BYTE_W] = {BYTE_W{eq16[k>>1]}};
				SZ_32:   eq_mask[k*BYTE_W +: BYTE_W] = {BYTE_W{eq32[k>>2]}};
				default: eq_mask[k*BYTE_W +: BYTE_W] = {BYTE_W{eq64}};
			endcase
		end
	end

	// Replicate the low element of the scalar across the word.
	always_comb begin
		unique case (size_class)
			SZ_8:    splat = {(WORD_W/8){scalar_value[7:0]}};
			SZ_16:   splat = {(WORD_W/16){scalar_value[15:0]}};
			SZ_32:   splat = {(WORD_W/32){scalar_value[31:0]}};
			default: splat = scalar_value;
		endcase
	end

	// Operation select; the unused code gives zero.
	always_comb begin
		unique case (opcode)
			OP_BCAST: result = splat;
			OP_SUB:   result = diff;
			OP_CMPEQ: result = eq_mask;
			default:  result = '0;
		endcase
	end

endmodule

`default_nettype wire

[src/pva_merge.sv]
// Merging stage: folds the per-lane match flags into the all-equal flag.
// Depends on pva_pkg for the merge_in_t status struct.
`default_nettype none

module pva_merge (
	input  wire pva_pkg::merge_in_t status,
	output logic                    all_equal
);
	import pva_pkg::*;

	// Only a compare raises the flag, and only when all lanes matched.
	assign all_equal = status.cmp_op & (&status.word_eq);

endmodule

`default_nettype wire

[src/packed_vector_alu_256.sv]
// Top level of the 256-bit packed vector ALU: four parallel lanes, a merge stage
// and an output register. Depends on pva_pkg, pva_lane and pva_merge.
//
// Channel  Dir  Handshake         Word contents
// s_*      in   s_tvalid/s_tready opcode, size_class, a_word0..3, b_word0..3, scalar
// m_*      out  m_tvalid/m_tready result_word0..3, all_equal
//
// One word is accepted per clock while s_tready is high; it passes stage 1 and the output register before m_tvalid.
// The lanes compute in the accepting cycle into stage 1, the merge feeds the output register.
// Stage 1 keeps taking words while a result waits, until both stages are full.
// arst_n clears both valid bits asynchronously; payload registers are not reset.
`default_nettype none

module packed_vector_alu_256 (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    s_tvalid,
	output logic                         s_tready,
	// [1:0] opcode, [3:2] size_class, [67:4] a_word0, [131:68] a_word1,
	// [195:132] a_word2, [259:196] a_word3, [323:260] b_word0, [387:324] b_word1,
	// [451:388] b_word2, [515:452] b_word3, [579:516] scalar_value, rest zero
	input  wire logic [pva_pkg::IN_W-1:0] s_tdata,
	output logic                         m_tvalid,
	input  wire logic                    m_tready,
	// [63:0] result_word0, [127:64] result_word1, [191:128] result_word2,
	// [255:192] result_word3, [256] all_equal, rest zero
	output logic [pva_pkg::OUT_W-1:0]    m_tdata
);
	import pva_pkg::*;

	logic [OP_W-1:0]   in_op;
	logic [SIZE_W-1:0] in_size;
	logic [WORD_W-1:0] in_scalar;
	logic [WORD_W-1:0] lane_res [NUM_LANES];
	logic [NUM_LANES-1:0] lane_eq;

	logic                 s_accept;
	logic                 s1_adv;
	logic                 valid_s1;
	logic [WORD_W-1:0]    res_s1 [NUM_LANES];
	merge_in_t            status_s1;
	logic                 all_equal;

	logic                 out_valid_q;
	logic [WORD_W-1:0]    out_res_q [NUM_LANES];
	logic                 out_eq_q;

	// Unpack the shared fields of the input word.
	assign in_op     = s_tdata[IN_OP_LSB +: OP_W];
	assign in_size   = s_tdata[IN_SIZE_LSB +: SIZE_W];
	assign in_scalar = s_tdata[IN_S_LSB +: WORD_W];

	// Four lanes, one per 64-bit word of the vector.
	for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
		pva_lane u_lane (
			.opcode       (in_op),
			.size_class   (in_size),
			.a            (s_tdata[IN_A_LSB + i*WORD_W +: WORD_W]),
			.b            (s_tdata[IN_B_LSB + i*WORD_W +: WORD_W]),
			.scalar_value (in_scalar),
			.result       (lane_res[i]),
			.word_eq      (lane_eq[i])
		);
	end

	// Pipeline flow control.
	assign s1_adv   = valid_s1 & (~out_valid_q | m_tready);
	assign s_tready = ~valid_s1 | s1_adv;
	assign s_accept = s_tvalid & s_tready;

	// Stage 1 valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Stage 1 payload: lane results and status for the merge.
	always_ff @(posedge clk) begin
		if (s_accept) begin
			for (int i = 0; i < NUM_LANES; i++) begin
				res_s1[i] <= lane_res[i];
			end
			status_s1.cmp_op  <= (in_op == OP_CMPEQ);
			status_s1.word_eq <= lane_eq;
		end
	end

	pva_merge u_merge (
		.status    (status_s1),
		.all_equal (all_equal)
	);

	// Output register valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (~out_valid_q | m_tready) begin
			out_valid_q <= valid_s1;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			for (int i = 0; i < NUM_LANES; i++) begin
				out_res_q[i] <= res_s1[i];
			end
			out_eq_q <= all_equal;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_W - OUT_RAW_W){1'b0}}, out_eq_q,
		out_res_q[3], out_res_q[2], out_res_q[1], out_res_q[0]};

	// A raised all-equal flag goes with an all-ones compare mask.
	a_eq_mask: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[NUM_LANES*WORD_W]) |-> (&m_tdata[NUM_LANES*WORD_W-1:0]))
		else $error("all_equal raised without an all-ones mask");

	// The merged flag only rises for a compare.
	a_eq_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && all_equal) |-> status_s1.cmp_op)
		else $error("all_equal raised for a non-compare operation");

	// A stage 1 word that cannot advance is held, not dropped.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !m_tready) |=> valid_s1)
		else $error("stage 1 word lost while output stalled");

	// A stalled output word keeps its valid bit and its all-equal flag.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |=> (out_valid_q && $stable(out_eq_q)))
		else $error("output word changed while stalled");

endmodule

`default_nettype wire

[test/tb.sv]
// Self-checking bench for packed_vector_alu_256: a table of directed words, then random words, each result compared
// with its table entry or an in-bench lane-wise predictor. Depends on pva_pkg and the RTL.
`default_nettype none

module tb;
	import pva_pkg::*;

	// Opcode that the block does not implement; it must give an all-zero result.
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	localparam int RANDOM_PER_PHASE = 310;
	localparam int HOLD_CYCLES      = 200;
	localparam int WATCHDOG_LIMIT   = 5000;
	localparam int DRAIN_CYCLES     = 8;
	localparam int REPORT_LIMIT     = 20;

	// Input word as packed on s_tdata, opcode in the lowest bits.
	typedef struct packed {
		logic [WORD_W-1:0]                scalar;
		logic [NUM_LANES-1:0][WORD_W-1:0] b;
		logic [NUM_LANES-1:0][WORD_W-1:0] a;
		logic [SIZE_W-1:0]                size;
		logic [OP_W-1:0]                  op;
	} alu_word_t;

	// Result word as packed on m_tdata.
	typedef struct packed {
		logic                             all_equal;
		logic [NUM_LANES-1:0][WORD_W-1:0] word;
	} alu_result_t;

	typedef struct {
		alu_word_t   item;
		bit          known;
		alu_result_t result;
	} stim_row_t;

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;

	alu_result_t expected_results[$];
	stim_row_t   directed_rows[$];
	int          fail_count;
	int          send_idle_pct;
	int          recv_idle_pct;
	int          quiet_cycles;
	logic        hold_pending;
	alu_result_t got_result;
	alu_result_t want_result;

	packed_vector_alu_256 uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Lane-wise result of one word: broadcast, wrapping subtract or compare-equal.
	function automatic alu_result_t packed_alu_result(alu_word_t it);
		alu_result_t       res;
		logic [WORD_W-1:0] lane_mask;
		logic [WORD_W-1:0] x;
		logic [WORD_W-1:0] y;
		logic [WORD_W-1:0] r;
		int                w;
		bit                all_match;
		w = 8 << it.size;
		lane_mask = (w == WORD_W) ? '1 : ((64'd1 << w) - 64'd1);
		all_match = 1'b1;
		res = '0;
		for (int i = 0; i < NUM_LANES; i++) begin
			r = '0;
			for (int s = 0; s < WORD_W; s += w) begin
				x = (it.a[i] >> s) & lane_mask;
				y = (it.b[i] >> s) & lane_mask;
				case (it.op)
					OP_BCAST: r |= (it.scalar & lane_mask) << s;
					OP_SUB:   r |= ((x - y) & lane_mask) << s;
					OP_CMPEQ: begin
						if (x == y)
							r |= lane_mask << s;
						else
							all_match = 1'b0;
					end
					default: ;
				endcase
			end
			res.word[i] = r;
		end
		res.all_equal = (it.op == OP_CMPEQ) && all_match;
		return res;
	endfunction

	// Random word: compare operands are often equal or differ in a few bytes only.
	function automatic alu_word_t random_alu_word();
		alu_word_t         it;
		logic [WORD_W-1:0] diff;
		int                pick;
		int                b_mode;
		pick = $urandom_range(99);
		it.op = (pick < 30) ? OP_BCAST : (pick < 62) ? OP_SUB :
			(pick < 95) ? OP_CMPEQ : OP_UNUSED;
		it.size = SIZE_W'($urandom_range(3));
		it.scalar = {$urandom, $urandom};
		b_mode = $urandom_range(3);
		for (int i = 0; i < NUM_LANES; i++) begin
			it.a[i] = {$urandom, $urandom};
			if ($urandom_range(15) == 0)
				it.a[i] = $urandom_range(1) ? '1 : '0;
			diff = '0;
			for (int k = 0; k < NUM_BYTES; k++) begin
				if ($urandom_range(7) == 0)
					diff[k*BYTE_W +: BYTE_W] = BYTE_W'($urandom_range(1, 255));
			end
			case (b_mode)
				0: it.b[i] = {$urandom, $urandom};
				1: it.b[i] = it.a[i];
				default: it.b[i] = it.a[i] ^ diff;
			endcase
		end
		return it;
	endfunction

	task automatic add_row(input logic [OP_W-1:0] op, input logic [SIZE_W-1:0] size,
			input logic [255:0] a, input logic [255:0] b, input logic [63:0] scalar,
			input bit known, input logic [255:0] words, input logic flag);
		stim_row_t row;
		row.item.op = op;
		row.item.size = size;
		row.item.a = a;
		row.item.b = b;
		row.item.scalar = scalar;
		row.known = known;
		row.result.word = words;
		row.result.all_equal = flag;
		directed_rows.push_back(row);
	endtask

	// Offer one word, with random gaps before it, and record its expected result on acceptance.
	task automatic send_word(input alu_word_t it, input bit known, input alu_result_t typed);
		logic [IN_W-1:0] bus;
		bus = '0;
		bus[$bits(alu_word_t)-1:0] = it;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= bus;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		expected_results.push_back(known ? typed : packed_alu_result(it));
	endtask

	task automatic report_mismatch(input string field, input logic [63:0] want,
			input logic [63:0] got);
		fail_count++;
		if (fail_count <= REPORT_LIMIT)
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
	endtask

	// Receiver: random stalls, plus one long hold-off requested by the sender process.
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_pending) begin
				hold_pending <= 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Result checker: every accepted result word is compared with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_result = m_tdata[$bits(alu_result_t)-1:0];
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result_word0", '0, got_result.word[0]);
			end else begin
				want_result = expected_results.pop_front();
				for (int i = 0; i < NUM_LANES; i++) begin
					if (got_result.word[i] !== want_result.word[i])
						report_mismatch($sformatf("result_word%0d", i),
							want_result.word[i], got_result.word[i]);
				end
				if (got_result.all_equal !== want_result.all_equal)
					report_mismatch("all_equal", 64'(want_result.all_equal),
						64'(got_result.all_equal));
			end
		end
	end

	// Watchdog on cycles in which neither side moves a word.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		hold_pending = 1'b0;
		fail_count = 0;
		quiet_cycles = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;

		// Broadcast per size, scalar high bits and vector operands ignored.
		add_row(OP_BCAST, SZ_8, '0, '0, 64'h0000_0000_0000_00A5, 1'b1, {32{8'hA5}}, 1'b0);
		add_row(OP_BCAST, SZ_16, {4{64'hDEAD_BEEF_0BAD_F00D}}, '1, 64'hFFFF_FFFF_FFFF_8001,
			1'b1, {16{16'h8001}}, 1'b0);
		add_row(OP_BCAST, SZ_32, '0, '0, 64'h1234_5678_9ABC_DEF0, 1'b1, {8{32'h9ABC_DEF0}},
			1'b0);
		add_row(OP_BCAST, SZ_64, '0, '0, '1, 1'b1, '1, 1'b0);
		add_row(OP_BCAST, SZ_64, '1, '1, '0, 1'b1, '0, 1'b0);
		// Subtract: zero minus one in every lane wraps to all ones; also equal operands and 80h minus 1.
		add_row(OP_SUB, SZ_8, '0, {32{8'h01}}, '1, 1'b1, '1, 1'b0);
		add_row(OP_SUB, SZ_16, '0, {16{16'h0001}}, '0, 1'b1, '1, 1'b0);
		add_row(OP_SUB, SZ_32, '0, {8{32'h0000_0001}}, '0, 1'b1, '1, 1'b0);
		add_row(OP_SUB, SZ_64, '0, {4{64'h1}}, '0, 1'b1, '1, 1'b0);
		add_row(OP_SUB, SZ_8, '1, '1, '1, 1'b1, '0, 1'b0);
		add_row(OP_SUB, SZ_8, {32{8'h80}}, {32{8'h01}}, '0, 1'b1, {32{8'h7F}}, 1'b0);
		// A borrow stays inside its lane.
		add_row(OP_SUB, SZ_64, {4{64'h0000_0001_0000_0000}}, {4{64'h1}}, '0,
			1'b1, {4{64'h0000_0000_FFFF_FFFF}}, 1'b0);
		add_row(OP_SUB, SZ_32, {4{64'h0000_0001_0000_0000}}, {4{64'h1}}, '0, 1'b0, '0, 1'b0);
		add_row(OP_SUB, SZ_16, {4{64'h0123_4567_89AB_CDEF}}, {4{64'hFEDC_BA98_7654_3210}},
			'1, 1'b0, '0, 1'b0);
		// Compare: fully equal, fully different and one lane off.
		add_row(OP_CMPEQ, SZ_8, {4{64'h0123_4567_89AB_CDEF}}, {4{64'h0123_4567_89AB_CDEF}},
			'1, 1'b1, '1, 1'b1);
		add_row(OP_CMPEQ, SZ_16, '1, '1, '0, 1'b1, '1, 1'b1);
		add_row(OP_CMPEQ, SZ_32, '0, '0, '0, 1'b1, '1, 1'b1);
		add_row(OP_CMPEQ, SZ_64, {4{64'hA5A5_5A5A_A5A5_5A5A}}, {4{64'hA5A5_5A5A_A5A5_5A5A}},
			'0, 1'b1, '1, 1'b1);
		add_row(OP_CMPEQ, SZ_8, '1, '0, '0, 1'b1, '0, 1'b0);
		add_row(OP_CMPEQ, SZ_8, {4{64'h0123_4567_89AB_CDEF}},
			{64'hFF23_4567_89AB_CDEF, {3{64'h0123_4567_89AB_CDEF}}}, '0, 1'b0, '0, 1'b0);
		add_row(OP_CMPEQ, SZ_64, {4{64'h0123_4567_89AB_CDEF}},
			{64'hFF23_4567_89AB_CDEF, {3{64'h0123_4567_89AB_CDEF}}}, '0, 1'b0, '0, 1'b0);
		add_row(OP_CMPEQ, SZ_16, {4{64'h0123_4567_89AB_CDEF}},
			{{3{64'h0123_4567_89AB_CDEF}}, 64'h0123_4567_89AB_CDEE}, '1, 1'b0, '0, 1'b0);
		// The unused opcode gives an all-zero result.
		add_row(OP_UNUSED, SZ_8, '1, '1, '1, 1'b1, '0, 1'b0);
		add_row(OP_UNUSED, SZ_64, {4{64'h0123_4567_89AB_CDEF}}, {4{64'h0123_4567_89AB_CDEF}},
			64'h1234_5678_9ABC_DEF0, 1'b1, '0, 1'b0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Three phases: sparse receiver, then sparse sender, then full rate with a long hold-off.
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 8;
					recv_idle_pct <= 64;
				end
				1: begin
					send_idle_pct = 64;
					recv_idle_pct <= 8;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct <= 0;
					hold_pending <= 1'b1;
				end
			endcase
			if (phase == 0) begin
				foreach (directed_rows[r])
					send_word(directed_rows[r].item, directed_rows[r].known,
						directed_rows[r].result);
			end
			repeat (RANDOM_PER_PHASE)
				send_word(random_alu_word(), 1'b0, '0);
		end
		s_tvalid <= 1'b0;

		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && expected_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire
